>>> rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tlssni_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tlssni_pkg;

	// widths of the position counters
	localparam int unsigned POS_W = 25;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// header constants
	localparam logic [7:0] CT_HANDSHAKE = 8'd22;
	localparam logic [7:0] HT_CLIENT_HELLO = 8'd1;
	localparam logic [15:0] FIXED_SKIP = 16'd34;   // client version and 32-byte random
	localparam logic [16:0] REC_HDR_LEN = 17'd5;
	localparam logic [POS_W-1:0] HS_HDR_END = 25'd9; // record header plus handshake header
	localparam logic [POS_W:0] MIN_TOTAL = 26'd5;

	typedef enum logic [4:0] {
		PH_CT, PH_VMAJ, PH_VMIN, PH_LEN_HI, PH_LEN_LO, PH_HT, PH_HL0, PH_HL1,
		PH_HL2, PH_FIXED, PH_SID_LEN, PH_SID_SKIP, PH_CS_HI, PH_CS_LO,
		PH_CS_SKIP, PH_CM_LEN, PH_CM_SKIP, PH_EXTS_HI, PH_EXTS_LO, PH_EXT_TOP,
		PH_ET_LO, PH_EL_HI, PH_EL_LO, PH_EXT_SKIP, PH_NL_HI, PH_NL_LO,
		PH_NAME_TOP, PH_NN_HI, PH_NN_LO, PH_NAME, PH_NAME_SKIP, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND, ST_SHORT, ST_INCOMPLETE, ST_NOT_HS, ST_NOT_CH, ST_NO_NAME, ST_MALFORMED
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        name_valid;
		logic [7:0]  name_byte;
		logic        name_last;
		logic        done_res;
		logic [2:0]  status;
		logic [15:0] name_length;
	} res_t;

	// phases that count down rem
	function automatic logic is_skip(input phase_t ph);
		case (ph) inside
			PH_FIXED, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EXT_SKIP, PH_NAME_SKIP:
				is_skip = 1'b1;
			default: is_skip = 1'b0;
		endcase
	endfunction

	// phase that follows a finished skip
	function automatic phase_t skip_next(input phase_t ph);
		case (ph)
			PH_FIXED:     skip_next = PH_SID_LEN;
			PH_SID_SKIP:  skip_next = PH_CS_HI;
			PH_CS_SKIP:   skip_next = PH_CM_LEN;
			PH_CM_SKIP:   skip_next = PH_EXTS_HI;
			PH_EXT_SKIP:  skip_next = PH_EXT_TOP;
			PH_NAME_SKIP: skip_next = PH_NAME_TOP;
			default:      skip_next = PH_DONE;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/tlssni_buf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tlssni_buf_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/tlssni_name_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tlssni_name_if;
	logic        valid;
	logic        ready;
	logic        name_valid;
	logic [7:0]  name_byte;
	logic        name_last;
	logic        done_res;
	logic [2:0]  status;
	logic [15:0] name_length;

	modport source(output valid, name_valid, name_byte, name_last, done_res, status,
		name_length, input ready);
	modport sink(input valid, name_valid, name_byte, name_last, done_res, status,
		name_length, output ready);
endinterface
`default_nettype wire

>>> rtl/tls_client_hello_sni_extract.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted byte is held in the input stage, and its result is registered in the result stage for name_stream
// throughput: one byte per cycle while name_stream takes results, set by the combinational phase update in the parser
// every accepted byte gives exactly one result transaction
// reset: arst_n low clears the input stage, the parser state and the result stage
// parser state also returns to its reset values after each last byte
`include "assert_macros.svh"
module tls_client_hello_sni_extract
	import tlssni_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	tlssni_buf_if.sink    buf_stream,
	tlssni_name_if.source name_stream
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     out_free;
	logic     advance;
	res_t     res;

	// a byte moves through the parser when the result stage can take it
	assign advance = valid_s1 && out_free;

	tlssni_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.buf_stream (buf_stream),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	tlssni_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.res     (res)
	);

	tlssni_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.res         (res),
		.out_free    (out_free),
		.name_stream (name_stream)
	);

	// checks
	`CHK_IMPL(a_last_is_name, clk, arst_n, name_stream.valid && name_stream.name_last, name_stream.name_valid)
	`CHK_IMPL(a_status_on_done, clk, arst_n, name_stream.valid && !name_stream.done_res, name_stream.status == ST_FOUND && name_stream.name_length == 16'd0)
	`CHK_NEXT(a_stalled_byte_kept, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule
`default_nettype wire

>>> rtl/tlssni_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
module tlssni_in_reg
	import tlssni_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	tlssni_buf_if.sink    buf_stream,
	input  wire logic     advance,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	// stage is free when empty or when its transaction moves on
	assign buf_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (buf_stream.ready) begin
			valid_s1 <= buf_stream.valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (buf_stream.valid && buf_stream.ready) begin
			item_s1.data_byte <= buf_stream.data_byte;
			item_s1.last_byte <= buf_stream.last_byte;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tlssni_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module tlssni_parser
	import tlssni_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     advance,
	input  wire in_item_t item_s1,
	output res_t          res
);

	phase_t            phase_q, phase_d;
	status_t           outcome_q, outcome_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [16:0]       rec_end_q, rec_end_d;
	logic [POS_W-1:0]  hs_end_q, hs_end_d;
	logic [15:0]       rem_q, rem_d;
	logic [POS_W-1:0]  nl_end_q, nl_end_d;
	logic [7:0]        hold_q, hold_d;
	logic              host_q, host_d;
	logic [15:0]       total_len_q, total_len_d;

	// per-byte phase update and result
	always_comb begin
		logic [7:0]   b;
		logic [15:0]  field_len;
		logic [POS_W:0] nl_sum;
		logic [POS_W:0] total;
		logic [POS_W:0] q;
		status_t      st;

		b = item_s1.data_byte;
		phase_d = phase_q;
		outcome_d = outcome_q;
		pos_d = pos_q;
		rec_end_d = rec_end_q;
		hs_end_d = hs_end_q;
		rem_d = rem_q;
		nl_end_d = nl_end_q;
		hold_d = hold_q;
		host_d = host_q;
		total_len_d = total_len_q;
		res = '0;
		field_len = {hold_q, b};
		nl_sum = '0;
		total = {1'b0, pos_q} + 26'd1;
		q = total;
		st = ST_FOUND;

		// settle finished skips and loop ends at this byte
		if (is_skip(phase_d) && rem_d == 16'd0) begin
			phase_d = skip_next(phase_d);
		end
		if (phase_d == PH_NAME_TOP && pos_q >= nl_end_d) begin
			phase_d = PH_EXT_TOP;
		end
		if (phase_d == PH_EXT_TOP && pos_q >= hs_end_d) begin
			outcome_d = ST_NO_NAME;
			phase_d = PH_DONE;
		end

		// field read at or past the handshake end
		if (phase_d != PH_DONE && phase_d > PH_HL2 && !is_skip(phase_d)
			&& pos_q >= hs_end_d) begin
			outcome_d = ST_MALFORMED;
			phase_d = PH_DONE;
		end

		// consume the byte
		case (phase_d)
			PH_CT: begin
				if (b != CT_HANDSHAKE) outcome_d = ST_NOT_HS;
				phase_d = PH_VMAJ;
			end
			PH_VMAJ: phase_d = PH_VMIN;
			PH_VMIN: phase_d = PH_LEN_HI;
			PH_LEN_HI: begin
				hold_d = b;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rec_end_d = {1'b0, field_len} + REC_HDR_LEN;
				phase_d = (outcome_d == ST_NOT_HS) ? PH_DONE : PH_HT;
			end
			PH_HT: begin
				if (b != HT_CLIENT_HELLO) begin
					outcome_d = ST_NOT_CH;
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_HL0;
				end
			end
			PH_HL0: begin
				hs_end_d = {1'b0, b, 16'h0000};
				phase_d = PH_HL1;
			end
			PH_HL1: begin
				hs_end_d = hs_end_d | {9'd0, b, 8'h00};
				phase_d = PH_HL2;
			end
			PH_HL2: begin
				hs_end_d = (hs_end_d | {17'd0, b}) + HS_HDR_END;
				rem_d = FIXED_SKIP;
				phase_d = PH_FIXED;
			end
			PH_SID_LEN: begin
				rem_d = {8'd0, b};
				phase_d = PH_SID_SKIP;
			end
			PH_CS_HI: begin
				hold_d = b;
				phase_d = PH_CS_LO;
			end
			PH_CS_LO: begin
				rem_d = field_len;
				phase_d = PH_CS_SKIP;
			end
			PH_CM_LEN: begin
				rem_d = {8'd0, b};
				phase_d = PH_CM_SKIP;
			end
			PH_EXTS_HI: phase_d = PH_EXTS_LO;
			PH_EXTS_LO: phase_d = PH_EXT_TOP;
			PH_EXT_TOP: begin
				hold_d = b;
				phase_d = PH_ET_LO;
			end
			PH_ET_LO: begin
				host_d = (hold_q == 8'd0) && (b == 8'd0);
				phase_d = PH_EL_HI;
			end
			PH_EL_HI: begin
				hold_d = b;
				phase_d = PH_EL_LO;
			end
			PH_EL_LO: begin
				if (host_q) begin
					phase_d = PH_NL_HI;
				end else begin
					rem_d = field_len;
					phase_d = PH_EXT_SKIP;
				end
			end
			PH_NL_HI: begin
				hold_d = b;
				phase_d = PH_NL_LO;
			end
			PH_NL_LO: begin
				nl_sum = {1'b0, pos_q} + 26'd1 + {10'd0, field_len};
				nl_end_d = (nl_sum > {1'b0, POS_MAX}) ? POS_MAX : nl_sum[POS_W-1:0];
				phase_d = PH_NAME_TOP;
			end
			PH_NAME_TOP: begin
				host_d = (b == 8'd0);
				phase_d = PH_NN_HI;
			end
			PH_NN_HI: begin
				hold_d = b;
				phase_d = PH_NN_LO;
			end
			PH_NN_LO: begin
				rem_d = field_len;
				if (host_q) begin
					total_len_d = field_len;
					if (field_len == 16'd0) begin
						outcome_d = ST_FOUND;
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_NAME;
					end
				end else begin
					phase_d = PH_NAME_SKIP;
				end
			end
			PH_NAME: begin
				res.name_valid = 1'b1;
				res.name_byte = b;
				rem_d = rem_d - 16'd1;
				if (rem_d == 16'd0) begin
					res.name_last = 1'b1;
					outcome_d = ST_FOUND;
					phase_d = PH_DONE;
				end
			end
			PH_FIXED, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EXT_SKIP, PH_NAME_SKIP: begin
				rem_d = rem_d - 16'd1;
			end
			default: ;
		endcase

		// end of buffer: jump any pending skip, then settle the final outcome
		if (item_s1.last_byte) begin
			if (phase_d != PH_DONE) begin
				if (is_skip(phase_d)) begin
					q = total + {10'd0, rem_d};
					phase_d = skip_next(phase_d);
				end
				if (phase_d == PH_NAME_TOP && q >= {1'b0, nl_end_d}) begin
					phase_d = PH_EXT_TOP;
				end
				if (phase_d == PH_EXT_TOP && q >= {1'b0, hs_end_d}) begin
					outcome_d = ST_NO_NAME;
					phase_d = PH_DONE;
				end
				if (phase_d != PH_DONE) outcome_d = ST_MALFORMED;
			end
			if (total < MIN_TOTAL) begin
				st = ST_SHORT;
			end else if ({9'd0, rec_end_d} > total) begin
				st = ST_INCOMPLETE;
			end else begin
				st = outcome_d;
			end
			res.done_res = 1'b1;
			res.status = st;
			res.name_length = (st == ST_FOUND) ? total_len_d : 16'd0;

			// back to reset for the next buffer
			phase_d = PH_CT;
			outcome_d = ST_NO_NAME;
			pos_d = '0;
			rec_end_d = '0;
			hs_end_d = '0;
			rem_d = '0;
			nl_end_d = '0;
			hold_d = '0;
			host_d = 1'b0;
			total_len_d = '0;
		end else begin
			pos_d = (pos_q == POS_MAX) ? POS_MAX : pos_q + 25'd1;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CT;
			outcome_q <= ST_NO_NAME;
			pos_q <= '0;
			rec_end_q <= '0;
			hs_end_q <= '0;
			rem_q <= '0;
			nl_end_q <= '0;
			hold_q <= '0;
			host_q <= 1'b0;
			total_len_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			outcome_q <= outcome_d;
			pos_q <= pos_d;
			rec_end_q <= rec_end_d;
			hs_end_q <= hs_end_d;
			rem_q <= rem_d;
			nl_end_q <= nl_end_d;
			hold_q <= hold_d;
			host_q <= host_d;
			total_len_q <= total_len_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tlssni_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
module tlssni_out_reg
	import tlssni_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire res_t     res,
	output logic          out_free,
	tlssni_name_if.source name_stream
);

	logic valid_q;
	res_t res_q;

	// register can take a new result when empty or being drained
	assign out_free = !valid_q || name_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign name_stream.valid = valid_q;
	assign name_stream.name_valid = res_q.name_valid;
	assign name_stream.name_byte = res_q.name_byte;
	assign name_stream.name_last = res_q.name_last;
	assign name_stream.done_res = res_q.done_res;
	assign name_stream.status = res_q.status;
	assign name_stream.name_length = res_q.name_length;

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import tlssni_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_CAP = 200;
	localparam int RANDOM_BYTES = 950;

	// handshake fields of one built ClientHello
	typedef struct {
		logic [7:0] rec_type;
		logic [7:0] hs_type;
		int sid_len;
		int cs_len;
		int cm_len;
		int pre_exts;
		int post_exts;
		bit with_sni;
		bit other_entry;
		int name_len;
		int hs_adj;
		int rec_adj;
	} hello_t;

	logic clk;
	logic arst_n;

	tlssni_buf_if buf_if();
	tlssni_name_if name_if();

	tls_client_hello_sni_extract DUT (
		.clk(clk),
		.arst_n(arst_n),
		.buf_stream(buf_if),
		.name_stream(name_if)
	);

	// predicted parser state
	phase_t cur_phase;
	logic [POS_W-1:0] byte_pos;
	logic [16:0] rec_end;
	logic [POS_W-1:0] hs_end;
	logic [15:0] skip_left;
	logic [POS_W-1:0] list_end;
	logic [7:0] held_byte;
	logic host_entry;
	status_t verdict;
	logic [15:0] name_total;

	res_t awaited[$];
	logic [7:0] frame[$];
	int sni_start;
	int name_start;

	int errors;
	int cycle_cnt;
	int byte_cnt;
	int buffer_cnt;
	int checked_cnt;
	int outcome_tally[7];
	int stall_left;
	bit steady_run;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				awaited.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------- prediction

	function automatic void clear_parser();
		cur_phase = PH_CT;
		byte_pos = '0;
		rec_end = '0;
		hs_end = '0;
		skip_left = '0;
		list_end = '0;
		held_byte = '0;
		host_entry = 1'b0;
		verdict = ST_NO_NAME;
		name_total = '0;
	endfunction

	// counting phases and where each one leads once exhausted
	function automatic bit skip_dest(input phase_t ph, output phase_t nx);
		nx = ph;
		case (ph)
			PH_FIXED:     nx = PH_SID_LEN;
			PH_SID_SKIP:  nx = PH_CS_HI;
			PH_CS_SKIP:   nx = PH_CM_LEN;
			PH_CM_SKIP:   nx = PH_EXTS_HI;
			PH_EXT_SKIP:  nx = PH_EXT_TOP;
			PH_NAME_SKIP: nx = PH_NAME_TOP;
			default:      return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// finish exhausted skips and the list and extension loop tests at position q
	function automatic void settle_phases(input logic [31:0] q_in, input bit ahead);
		logic [31:0] q;
		phase_t nx;
		bit go;
		q = q_in;
		go = 1'b1;
		while (go) begin
			if (skip_dest(cur_phase, nx)) begin
				if (skip_left == 0) begin
					cur_phase = nx;
				end else if (!ahead) begin
					go = 1'b0;
				end else begin
					q = q + skip_left;
					skip_left = '0;
					cur_phase = nx;
				end
			end else if (cur_phase == PH_EXT_TOP) begin
				if (q >= hs_end) begin
					verdict = ST_NO_NAME;
					cur_phase = PH_DONE;
				end
				go = 1'b0;
			end else if (cur_phase == PH_NAME_TOP && q >= list_end) begin
				cur_phase = PH_EXT_TOP;
			end else begin
				go = 1'b0;
			end
		end
	endfunction

	// expected result for one accepted buffer byte
	function automatic res_t parse_byte(input logic [7:0] b, input logic is_last);
		res_t r;
		logic [31:0] p;
		logic [31:0] w;
		logic [31:0] total;
		phase_t nx;
		status_t st;
		r = '0;
		p = {7'd0, byte_pos};
		settle_phases(p, 1'b0);
		// any field read at or past the handshake end is malformed
		if (cur_phase != PH_DONE && cur_phase > PH_HL2 && !skip_dest(cur_phase, nx)
			&& p >= hs_end) begin
			verdict = ST_MALFORMED;
			cur_phase = PH_DONE;
		end
		case (cur_phase)
			PH_CT: begin
				if (b != CT_HANDSHAKE)
					verdict = ST_NOT_HS;
				cur_phase = PH_VMAJ;
			end
			PH_VMAJ: cur_phase = PH_VMIN;
			PH_VMIN: cur_phase = PH_LEN_HI;
			PH_LEN_HI: begin
				held_byte = b;
				cur_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rec_end = {1'b0, held_byte, b} + REC_HDR_LEN;
				if (verdict == ST_NOT_HS)
					cur_phase = PH_DONE;
				else
					cur_phase = PH_HT;
			end
			PH_HT: begin
				if (b != HT_CLIENT_HELLO) begin
					verdict = ST_NOT_CH;
					cur_phase = PH_DONE;
				end else begin
					cur_phase = PH_HL0;
				end
			end
			PH_HL0: begin
				hs_end = {1'b0, b, 16'h0000};
				cur_phase = PH_HL1;
			end
			PH_HL1: begin
				hs_end[15:8] = b;
				cur_phase = PH_HL2;
			end
			PH_HL2: begin
				hs_end = {hs_end[POS_W-1:8], b} + HS_HDR_END;
				skip_left = FIXED_SKIP;
				cur_phase = PH_FIXED;
			end
			PH_SID_LEN: begin
				skip_left = {8'h00, b};
				cur_phase = PH_SID_SKIP;
			end
			PH_CS_HI: begin
				held_byte = b;
				cur_phase = PH_CS_LO;
			end
			PH_CS_LO: begin
				skip_left = {held_byte, b};
				cur_phase = PH_CS_SKIP;
			end
			PH_CM_LEN: begin
				skip_left = {8'h00, b};
				cur_phase = PH_CM_SKIP;
			end
			PH_EXTS_HI: cur_phase = PH_EXTS_LO;
			PH_EXTS_LO: cur_phase = PH_EXT_TOP;
			PH_EXT_TOP: begin
				held_byte = b;
				cur_phase = PH_ET_LO;
			end
			PH_ET_LO: begin
				host_entry = (held_byte == 8'h00 && b == 8'h00);
				cur_phase = PH_EL_HI;
			end
			PH_EL_HI: begin
				held_byte = b;
				cur_phase = PH_EL_LO;
			end
			PH_EL_LO: begin
				if (host_entry) begin
					cur_phase = PH_NL_HI;
				end else begin
					skip_left = {held_byte, b};
					cur_phase = PH_EXT_SKIP;
				end
			end
			PH_NL_HI: begin
				held_byte = b;
				cur_phase = PH_NL_LO;
			end
			PH_NL_LO: begin
				w = p + 32'd1 + {16'd0, held_byte, b};
				list_end = (w > POS_MAX) ? POS_MAX : w[POS_W-1:0];
				cur_phase = PH_NAME_TOP;
			end
			PH_NAME_TOP: begin
				host_entry = (b == 8'h00);
				cur_phase = PH_NN_HI;
			end
			PH_NN_HI: begin
				held_byte = b;
				cur_phase = PH_NN_LO;
			end
			PH_NN_LO: begin
				skip_left = {held_byte, b};
				if (host_entry) begin
					name_total = {held_byte, b};
					if (name_total == 0) begin
						verdict = ST_FOUND;
						cur_phase = PH_DONE;
					end else begin
						cur_phase = PH_NAME;
					end
				end else begin
					cur_phase = PH_NAME_SKIP;
				end
			end
			PH_NAME: begin
				r.name_valid = 1'b1;
				r.name_byte = b;
				skip_left = skip_left - 16'd1;
				if (skip_left == 0) begin
					r.name_last = 1'b1;
					verdict = ST_FOUND;
					cur_phase = PH_DONE;
				end
			end
			PH_FIXED, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EXT_SKIP, PH_NAME_SKIP:
				skip_left = skip_left - 16'd1;
			default: ;
		endcase

		// final status on the last byte, then back to the start
		if (is_last) begin
			total = p + 32'd1;
			if (cur_phase != PH_DONE) begin
				settle_phases(total, 1'b1);
				if (cur_phase != PH_DONE)
					verdict = ST_MALFORMED;
			end
			if (total < 32'd5)
				st = ST_SHORT;
			else if ({15'd0, rec_end} > total)
				st = ST_INCOMPLETE;
			else
				st = verdict;
			r.done_res = 1'b1;
			r.status = st;
			r.name_length = (st == ST_FOUND) ? name_total : 16'h0000;
			clear_parser();
		end else begin
			byte_pos = (byte_pos == POS_MAX) ? POS_MAX : byte_pos + 1'b1;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void cmp_field(input string fname, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			if (errors < PRINT_CAP)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			errors++;
		end
	endfunction

	task automatic check_result();
		res_t want;
		if (awaited.size() == 0) begin
			$display("%0t: result transaction with nothing expected, actual status %0d",
				$time, name_if.status);
			errors++;
			return;
		end
		want = awaited.pop_front();
		checked_cnt++;
		if (want.done_res)
			outcome_tally[want.status]++;
		cmp_field("name_valid", want.name_valid, name_if.name_valid);
		cmp_field("name_byte", want.name_byte, name_if.name_byte);
		cmp_field("name_last", want.name_last, name_if.name_last);
		cmp_field("done_res", want.done_res, name_if.done_res);
		cmp_field("status", want.status, name_if.status);
		cmp_field("name_length", want.name_length, name_if.name_length);
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// result side: check each transaction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (name_if.valid && name_if.ready)
				check_result();
			if (stall_left == 0 && !steady_run && $urandom_range(0, 99) < 20)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				name_if.ready <= 1'b0;
				stall_left--;
			end else begin
				name_if.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		gap = (!steady_run && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			buf_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		buf_if.valid <= 1'b1;
		buf_if.data_byte <= b;
		buf_if.last_byte <= is_last;
		@(posedge clk);
		while (!buf_if.ready) @(posedge clk);
		awaited.push_back(parse_byte(b, is_last));
		byte_cnt++;
	endtask

	task automatic send_buffer();
		steady_run = ($urandom_range(0, 99) < 15);
		foreach (frame[i])
			send_byte(frame[i], i == frame.size() - 1);
		buffer_cnt++;
	endtask

	// stop sending until every expected result is back
	task automatic wait_drained();
		buf_if.valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void put8(input logic [7:0] b);
		frame.push_back(b);
	endfunction

	function automatic void put16(input int v);
		put8(v[15:8]);
		put8(v[7:0]);
	endfunction

	function automatic void put_rand(input int n);
		repeat (n) put8($urandom_range(0, 255));
	endfunction

	function automatic void patch16(input int idx, input int v);
		frame[idx] = v[15:8];
		frame[idx + 1] = v[7:0];
	endfunction

	function automatic void set_hs_len(input int v);
		frame[6] = v[23:16];
		patch16(7, v[15:0]);
	endfunction

	function automatic void cut_frame(input int keep);
		while (frame.size() > keep) void'(frame.pop_back());
	endfunction

	// extension of some other type, low byte zero, high byte zero or high byte nonzero
	function automatic void add_plain_ext();
		int pick;
		int n;
		pick = $urandom_range(0, 2);
		if (pick == 0)
			put16($urandom_range(1, 255));
		else if (pick == 1)
			put16($urandom_range(1, 255) << 8);
		else
			put16($urandom_range(256, 65535));
		n = $urandom_range(0, 6);
		put16(n);
		put_rand(n);
	endfunction

	function automatic hello_t typical_hello();
		hello_t h;
		h.rec_type = CT_HANDSHAKE;
		h.hs_type = HT_CLIENT_HELLO;
		h.sid_len = $urandom_range(0, 8);
		h.cs_len = 2 * $urandom_range(1, 3);
		h.cm_len = $urandom_range(1, 2);
		h.pre_exts = $urandom_range(0, 2);
		h.post_exts = $urandom_range(0, 1);
		h.with_sni = 1'b1;
		h.other_entry = 1'b0;
		h.name_len = $urandom_range(3, 16);
		h.hs_adj = 0;
		h.rec_adj = 0;
		return h;
	endfunction

	function automatic void build_hello(input hello_t h);
		int ext_at;
		int n;
		int hs_len;
		int rec_len;
		frame.delete();
		sni_start = -1;
		name_start = -1;
		// record and handshake headers, lengths filled in at the end
		put8(h.rec_type);
		put16(16'h0301);
		put16(0);
		put8(h.hs_type);
		put8(0);
		put16(0);
		put16(16'h0303);
		put_rand(32);
		put8(h.sid_len);
		put_rand(h.sid_len);
		put16(h.cs_len);
		put_rand(h.cs_len);
		put8(h.cm_len);
		put_rand(h.cm_len);
		ext_at = frame.size();
		put16(0);
		repeat (h.pre_exts) add_plain_ext();
		if (h.with_sni) begin
			sni_start = frame.size();
			put16(0);
			put16(0);
			put16(0);
			if (h.other_entry) begin
				n = $urandom_range(0, 4);
				put8($urandom_range(1, 255));
				put16(n);
				put_rand(n);
			end
			put8(0);
			put16(h.name_len);
			name_start = frame.size();
			put_rand(h.name_len);
			patch16(sni_start + 2, frame.size() - sni_start - 4);
			patch16(sni_start + 4, frame.size() - sni_start - 6);
		end
		repeat (h.post_exts) add_plain_ext();
		patch16(ext_at, frame.size() - ext_at - 2);
		hs_len = frame.size() - 9 + h.hs_adj;
		rec_len = frame.size() - 5 + h.rec_adj;
		if (hs_len < 0)
			hs_len = 0;
		if (rec_len < 0)
			rec_len = 0;
		if (rec_len > 65535)
			rec_len = 65535;
		set_hs_len(hs_len);
		patch16(3, rec_len);
	endfunction

	function automatic void build_noise(input int n);
		frame.delete();
		put_rand(n);
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_short_buffers();
		build_noise(1);
		frame[0] = 8'hff;
		send_buffer();
		build_noise(4);
		frame[0] = CT_HANDSHAKE;
		send_buffer();
		// record header only, zero length
		frame.delete();
		put8(CT_HANDSHAKE);
		put16(16'h0301);
		put16(0);
		send_buffer();
	endtask

	task automatic test_header_checks();
		hello_t h;
		h = typical_hello();
		h.rec_type = 8'h17;
		build_hello(h);
		send_buffer();
		h = typical_hello();
		h.hs_type = 8'h02;
		build_hello(h);
		send_buffer();
		h = typical_hello();
		h.rec_adj = 40;
		build_hello(h);
		send_buffer();
		// record length larger than the buffer but type already wrong
		h = typical_hello();
		h.rec_type = 8'h00;
		h.rec_adj = 1000;
		build_hello(h);
		send_buffer();
	endtask

	task automatic test_name_layouts();
		hello_t h;
		h = typical_hello();
		build_hello(h);
		send_buffer();
		// empty host name
		h = typical_hello();
		h.name_len = 0;
		h.post_exts = 1;
		build_hello(h);
		send_buffer();
		// non-host entry first in the list, several extensions around it
		h = typical_hello();
		h.pre_exts = 3;
		h.post_exts = 2;
		h.other_entry = 1'b1;
		build_hello(h);
		send_buffer();
		// no server name extension at all
		h = typical_hello();
		h.with_sni = 1'b0;
		h.pre_exts = 2;
		build_hello(h);
		send_buffer();
		// long name crossing a length byte boundary
		h = typical_hello();
		h.name_len = 300;
		build_hello(h);
		send_buffer();
		// widest session id and compression list, no cipher suites
		h = typical_hello();
		h.sid_len = 255;
		h.cs_len = 0;
		h.cm_len = 255;
		build_hello(h);
		send_buffer();
	endtask

	task automatic test_handshake_bounds();
		hello_t h;
		h = typical_hello();
		h.pre_exts = 1;
		// handshake ends where the server name extension starts
		build_hello(h);
		set_hs_len(sni_start - 9);
		send_buffer();
		// handshake ends inside the extension before it
		build_hello(h);
		set_hs_len(sni_start - 10);
		send_buffer();
		// handshake ends inside the name
		build_hello(h);
		set_hs_len(name_start + 2 - 9);
		send_buffer();
		// handshake length far beyond the buffer
		build_hello(h);
		set_hs_len(24'hffffff);
		send_buffer();
		// zero handshake length
		build_hello(h);
		set_hs_len(0);
		send_buffer();
	endtask

	task automatic test_truncated_buffers();
		hello_t h;
		h = typical_hello();
		h.pre_exts = 1;
		h.post_exts = 1;
		build_hello(h);
		cut_frame(name_start + 1);
		send_buffer();
		// buffer ends right on the last name byte
		build_hello(h);
		cut_frame(name_start + h.name_len);
		send_buffer();
		// buffer ends inside the extension before the server name extension
		build_hello(h);
		cut_frame(sni_start - 1);
		send_buffer();
		// buffer ends just after the handshake header
		build_hello(h);
		cut_frame(9);
		send_buffer();
	endtask

	task automatic test_random_traffic();
		hello_t h;
		int start_bytes;
		int pick;
		wait_drained();
		start_bytes = byte_cnt;
		while (byte_cnt - start_bytes < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			h = typical_hello();
			h.pre_exts = $urandom_range(0, 3);
			h.other_entry = ($urandom_range(0, 99) < 30);
			h.with_sni = ($urandom_range(0, 99) < 85);
			if ($urandom_range(0, 9) == 0)
				h.name_len = 0;
			if ($urandom_range(0, 19) == 0)
				h.rec_type = $urandom_range(0, 255);
			if ($urandom_range(0, 19) == 0)
				h.hs_type = $urandom_range(0, 255);
			if (pick >= 80 && pick < 88) begin
				h.hs_adj = $urandom_range(0, 40) - 20;
				h.rec_adj = $urandom_range(0, 9) == 0 ? $urandom_range(1, 30) : 0;
			end
			build_hello(h);
			if (pick >= 55 && pick < 70) begin
				cut_frame($urandom_range(1, frame.size() - 1));
			end else if (pick >= 70 && pick < 80) begin
				repeat ($urandom_range(1, 2))
					frame[$urandom_range(0, frame.size() - 1)] = $urandom_range(0, 255);
			end else if (pick >= 88) begin
				build_noise($urandom_range(1, 12));
				if ($urandom_range(0, 1) == 0)
					frame[0] = CT_HANDSHAKE;
			end
			send_buffer();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		buf_if.valid = 1'b0;
		buf_if.data_byte = 8'h00;
		buf_if.last_byte = 1'b0;
		name_if.ready = 1'b0;
		steady_run = 1'b0;
		errors = 0;
		cycle_cnt = 0;
		byte_cnt = 0;
		buffer_cnt = 0;
		checked_cnt = 0;
		foreach (outcome_tally[i])
			outcome_tally[i] = 0;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_buffers();
		test_header_checks();
		test_name_layouts();
		test_handshake_bounds();
		test_truncated_buffers();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("tb: %0d buffers, %0d bytes, %0d result transactions checked",
			buffer_cnt, byte_cnt, checked_cnt);
		$display("tb: found %0d short %0d incomplete %0d not-hs %0d not-ch %0d no-name %0d bad %0d",
			outcome_tally[ST_FOUND], outcome_tally[ST_SHORT], outcome_tally[ST_INCOMPLETE],
			outcome_tally[ST_NOT_HS], outcome_tally[ST_NOT_CH], outcome_tally[ST_NO_NAME],
			outcome_tally[ST_MALFORMED]);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
